### design/tsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsl_pkg;

    // field widths
    localparam int OP_W  = 2;
    localparam int IDX_W = 7;
    localparam int OFS_W = 32;
    localparam int DIR_W = 2;
    localparam int TC_W  = 8;
    localparam int THR_W = 20;
    localparam int CFG_W = 20;
    localparam int CFG_IDX_W = 1;

    // table size default
    localparam int TABLE_DEPTH_DEF = 128;

    // skip threshold after reset
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(3000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRACKS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_THR   = 1'b1;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WRITE  = 2'd0,
        OP_LOCATE = 2'd1,
        OP_SKIP   = 2'd2,
        OP_CHECK  = 2'd3
    } t_op;

    // table read address select
    typedef enum logic [2:0] {
        RD_NEXT     = 3'd0,
        RD_FIRST    = 3'd1,
        RD_TRACK    = 3'd2,
        RD_CUR      = 3'd3,
        RD_CUR_NEXT = 3'd4
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        t_rd_sel rd_sel;
        logic    j_init;
        logic    j_inc;
        logic    loc_commit;
        logic    sk_eval;
        logic    sk_target;
        logic    set_chg;
        logic    out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic n_zero;
        logic walk_done;
        logic op_skip;
        logic ck_low;
        logic ck_high;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### design/track_segment_locator_unit.sv
// Track segment locator: holds a table of track start offsets (ms) and the
// current track. Each input word is one operation: write a table entry,
// locate the track holding a position, skip forward/backward/restart with a
// seek request, or check whether playback has left the current track. Every
// word yields exactly one output word. Words are handled one at a time; the
// block takes a new word once the previous one has moved to the output
// register, so a waiting result does not hold off the next word. A locate
// walks the offset table one entry per cycle through its single registered
// read port; a skip follows its locate with a read, an evaluation, a second
// read and a target step, and a check on a non-empty sheet reads the current
// and next offsets and runs a locate when the track changed. Every operation
// waits to load its result while the output register is stalled. The table
// is not cleared at reset: entries must be written before any operation
// reads them.
`timescale 1ns / 1ps
`default_nettype none

module track_segment_locator_unit #(
    parameter int TABLE_DEPTH = tsl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tsl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tsl_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [tsl_pkg::OP_W-1:0]         i_operation,
    input  wire logic [tsl_pkg::IDX_W-1:0]        i_entry_index,
    input  wire logic [tsl_pkg::OFS_W-1:0]        i_entry_offset_ms,
    input  wire logic [tsl_pkg::OFS_W-1:0]        i_position_ms,
    input  wire logic signed [tsl_pkg::DIR_W-1:0] i_direction,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [tsl_pkg::IDX_W-1:0]             o_track_index,
    output logic                                  o_seek_request,
    output logic [tsl_pkg::OFS_W-1:0]             o_target_offset_ms,
    output logic                                  o_in_sheet,
    output logic                                  o_changed
);
    import tsl_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    tsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_stall     (o_stall)
    );

    // table, track state and output register
    tsl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_entry_index      (i_entry_index),
        .i_entry_offset_ms  (i_entry_offset_ms),
        .i_position_ms      (i_position_ms),
        .i_direction        (i_direction),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_track_index      (o_track_index),
        .o_seek_request     (o_seek_request),
        .o_target_offset_ms (o_target_offset_ms),
        .o_in_sheet         (o_in_sheet),
        .o_changed          (o_changed)
    );

endmodule

`default_nettype wire

### design/tsl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsl_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire logic [tsl_pkg::OP_W-1:0] i_operation,
    input  wire tsl_pkg::t_status         i_status,
    output tsl_pkg::t_cmd                 o_cmd,
    output logic                          o_stall
);
    import tsl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_PRIME   = 11'b000_0000_0010,
        S_WALK    = 11'b000_0000_0100,
        S_SK_RDA  = 11'b000_0000_1000,
        S_SK_EVAL = 11'b000_0001_0000,
        S_SK_RDB  = 11'b000_0010_0000,
        S_SK_TGT  = 11'b000_0100_0000,
        S_CK_RDA  = 11'b000_1000_0000,
        S_CK_RDB  = 11'b001_0000_0000,
        S_CK_EVB  = 11'b010_0000_0000,
        S_FIN     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // new words only in idle
    assign o_stall = (r_state != S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.rd_sel     = RD_NEXT;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (t_op'(i_operation))
                        OP_WRITE:  n_state = S_FIN;
                        OP_LOCATE: n_state = S_PRIME;
                        OP_SKIP:   n_state = S_PRIME;
                        OP_CHECK:  n_state = i_status.n_zero ? S_FIN : S_CK_RDA;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_PRIME: begin
                o_cmd.rd_sel = RD_FIRST;
                o_cmd.j_init = 1'b1;
                n_state      = S_WALK;
            end
            S_WALK: begin
                o_cmd.rd_sel = RD_NEXT;
                if (i_status.walk_done) begin
                    o_cmd.loc_commit = 1'b1;
                    n_state = i_status.op_skip ? S_SK_RDA : S_FIN;
                end else begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            S_SK_RDA: begin
                o_cmd.rd_sel = RD_TRACK;
                n_state      = S_SK_EVAL;
            end
            S_SK_EVAL: begin
                o_cmd.sk_eval = 1'b1;
                n_state       = S_SK_RDB;
            end
            S_SK_RDB: begin
                o_cmd.rd_sel = RD_TRACK;
                n_state      = S_SK_TGT;
            end
            S_SK_TGT: begin
                o_cmd.sk_target = 1'b1;
                n_state         = S_FIN;
            end
            S_CK_RDA: begin
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_CK_RDB;
            end
            S_CK_RDB: begin
                o_cmd.rd_sel = RD_CUR_NEXT;
                if (i_status.ck_low) begin
                    o_cmd.set_chg = 1'b1;
                    n_state       = S_PRIME;
                end else begin
                    n_state = S_CK_EVB;
                end
            end
            S_CK_EVB: begin
                if (i_status.ck_high) begin
                    o_cmd.set_chg = 1'b1;
                    n_state       = S_PRIME;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/tsl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tsl_dp #(
    parameter int TABLE_DEPTH = tsl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tsl_pkg::t_cmd                    i_cmd,
    output tsl_pkg::t_status                      o_status,
    input  wire logic                             i_cfg_we,
    input  wire logic [tsl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tsl_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic [tsl_pkg::OP_W-1:0]         i_operation,
    input  wire logic [tsl_pkg::IDX_W-1:0]        i_entry_index,
    input  wire logic [tsl_pkg::OFS_W-1:0]        i_entry_offset_ms,
    input  wire logic [tsl_pkg::OFS_W-1:0]        i_position_ms,
    input  wire logic signed [tsl_pkg::DIR_W-1:0] i_direction,
    input  wire logic                             i_stall,
    output logic                                  o_valid,
    output logic [tsl_pkg::IDX_W-1:0]             o_track_index,
    output logic                                  o_seek_request,
    output logic [tsl_pkg::OFS_W-1:0]             o_target_offset_ms,
    output logic                                  o_in_sheet,
    output logic                                  o_changed
);
    import tsl_pkg::*;

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > TC_W) ? CNT_W : TC_W;
    localparam int EW    = (IW + 1 > IDX_W) ? IW + 1 : IDX_W;

    // configuration registers
    logic [TC_W-1:0]  r_num_tracks;
    logic [THR_W-1:0] r_skip_thr;

    // captured word
    logic [OP_W-1:0]  r_op;
    logic [OFS_W-1:0] r_pos;
    logic [DIR_W-1:0] r_dir;

    // walk and track state
    logic [CNT_W-1:0] r_j;
    logic [IW-1:0]    r_cur;
    logic [IW-1:0]    r_t;

    // result fields
    logic             r_seek;
    logic [OFS_W-1:0] r_target;
    logic             r_stay;
    logic             r_chg;

    // offset table
    logic [OFS_W-1:0] r_mem [TABLE_DEPTH];
    logic [OFS_W-1:0] r_rd_data;
    logic [IW-1:0]    rd_addr;

    logic [CNT_W-1:0] valid_cnt;
    logic [CNT_W-1:0] j_plus;
    logic [CNT_W-1:0] j_minus;
    logic [CNT_W-1:0] cur_plus;
    logic [IW-1:0]    n_t;
    logic             n_seek;
    logic [OFS_W-1:0] elapsed;
    logic             dir_fwd;
    logic             dir_nonneg;
    logic             dir_nonpos;
    logic             dir_neg;
    logic             write_hit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_tracks <= '0;
            r_skip_thr   <= THR_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_NUM_TRACKS) begin
                r_num_tracks <= i_cfg_data[TC_W-1:0];
            end else if (i_cfg_index == CFG_SKIP_THR) begin
                r_skip_thr <= i_cfg_data[THR_W-1:0];
            end
        end
    end

    // track count clamped to the table size
    assign valid_cnt = (CMP_W'(r_num_tracks) > CMP_W'(TABLE_DEPTH)) ?
                       CNT_W'(TABLE_DEPTH) : CNT_W'(r_num_tracks);

    assign j_plus   = r_j + CNT_W'(1);
    assign j_minus  = r_j - CNT_W'(1);
    assign cur_plus = CNT_W'(r_cur) + CNT_W'(1);

    assign dir_fwd    = (r_dir == 2'b01);
    assign dir_nonneg = !r_dir[1];
    assign dir_nonpos = (r_dir != 2'b01);
    assign dir_neg    = r_dir[1];

    assign write_hit = (t_op'(i_operation) == OP_WRITE) &&
                       (EW'(i_entry_index) < EW'(TABLE_DEPTH));

    // table read address
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_NEXT:     rd_addr = j_plus[IW-1:0];
            RD_FIRST:    rd_addr = IW'(1);
            RD_TRACK:    rd_addr = r_t;
            RD_CUR:      rd_addr = r_cur;
            RD_CUR_NEXT: rd_addr = cur_plus[IW-1:0];
            default:     rd_addr = r_t;
        endcase
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && write_hit) begin
            r_mem[IW'(i_entry_index)] <= i_entry_offset_ms;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // skip decision on the located track
    assign elapsed = r_pos - r_rd_data;

    always_comb begin
        n_t    = r_t;
        n_seek = 1'b0;
        if ((valid_cnt != '0) &&
            !(dir_nonneg && (CNT_W'(r_t) == valid_cnt - CNT_W'(1)))) begin
            n_seek = 1'b1;
            if (!(dir_nonpos && (r_t == '0))) begin
                if (dir_fwd) begin
                    n_t = r_t + IW'(1);
                end else if (dir_neg && (elapsed < OFS_W'(r_skip_thr))) begin
                    n_t = r_t - IW'(1);
                end
            end
        end
    end

    // status to the controller
    assign o_status.n_zero    = (valid_cnt == '0);
    assign o_status.walk_done = (r_j >= valid_cnt) || !(r_rd_data < r_pos);
    assign o_status.op_skip   = (t_op'(r_op) == OP_SKIP);
    assign o_status.ck_low    = (r_pos < r_rd_data);
    assign o_status.ck_high   = (cur_plus < valid_cnt) && (r_pos >= r_rd_data);
    assign o_status.out_free  = !o_valid || !i_stall;

    // current track
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_cmd.loc_commit) begin
            r_cur <= j_minus[IW-1:0];
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_operation;
            r_pos    <= i_position_ms;
            r_dir    <= i_direction;
            r_seek   <= 1'b0;
            r_stay   <= 1'b0;
            r_target <= '0;
            r_chg    <= 1'b0;
        end
        if (i_cmd.j_init) begin
            r_j <= CNT_W'(1);
        end else if (i_cmd.j_inc) begin
            r_j <= j_plus;
        end
        if (i_cmd.loc_commit) begin
            r_t <= j_minus[IW-1:0];
        end else if (i_cmd.sk_eval) begin
            r_t <= n_t;
        end
        if (i_cmd.sk_eval) begin
            r_seek <= n_seek;
            r_stay <= n_seek;
        end
        if (i_cmd.sk_target) begin
            r_target <= r_seek ? r_rd_data : '0;
        end
        if (i_cmd.set_chg) begin
            r_chg <= 1'b1;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_track_index      <= IDX_W'(r_cur);
            o_seek_request     <= r_seek;
            o_target_offset_ms <= r_target;
            o_in_sheet         <= r_stay;
            o_changed          <= r_chg;
        end
    end

endmodule

`default_nettype wire
